// ----- design/eol_pkg.sv -----
// Shared types, constants and helpers for the envelope overshoot limiter.
package eol_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_WINDOW_DEF  = 255;
  localparam int GAIN_FRAC       = 12;
  localparam int GAIN_BITS       = 16;
  localparam int WLEN_BITS       = 8;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_ADDR_BITS   = 4;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  localparam logic                 ENABLE_RST = 1'b1;
  localparam logic [GAIN_BITS-1:0] GAIN_RST   = 16'd4096;
  localparam logic [WLEN_BITS-1:0] WINDOW_RST = 8'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQRT,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } eol_state_t;

  // Window length is forced odd, at least three and no larger than the line.
  function automatic logic [WLEN_BITS-1:0] clamp_window(input logic [WLEN_BITS-1:0] raw,
                                                        input int max_w);
    int v;
    begin
      v = int'(raw);
      if (v < 3) v = 3;
      if ((v % 2) == 0) v = v + 1;
      if (v > max_w) begin
        v = max_w;
        if ((v % 2) == 0) v = v - 1;
      end
      clamp_window = WLEN_BITS'(v);
    end
  endfunction

endpackage

// ----- design/envelope_overshoot_limiter_top.sv -----
// Top level of the envelope overshoot limiter with stream ports and register port.
//
// Each input transaction carries one complex sample. With control enabled, the sample enters
// a circular delay line and its magnitude enters an envelope line; the block tracks the peak
// envelope over the window and returns the sample from half a window earlier, divided by
// 1 + gain*(peak - 1) whenever the peak is above 1.0. With control disabled the sample is
// returned unchanged in the cycle after it is taken. One transaction is processed at a time.
// An enabled transaction passes through the magnitude step (squaring, loading and one root
// bit per cycle), a rescan of the envelope memory one entry per cycle when the envelope
// leaving the window was the peak, the multiply, the serial divider when the peak is above
// 1.0 (one quotient bit per cycle), and the hand-over of the result to the output register.
// After reset, and after every write of window_length, a clearing pass zeroes the memories;
// no input is taken during it, though register writes are. A result waits in the output
// register while the output side stalls, and no new transaction is taken until it has been
// passed on; the next one can be accepted in the cycle it leaves.
module envelope_overshoot_limiter_top import eol_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata fields from bit 0 up: in_i, in_q, zero fill to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  // Output stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata fields from bit 0 up: out_i, out_q, zero fill to whole bytes.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
  // Register port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [CFG_ADDR_BITS-1:0]             paddr,
  input  logic [CFG_DATA_BITS-1:0]             pwdata,
  output logic [CFG_DATA_BITS-1:0]             prdata,
  output logic                                 pready
);

  localparam int TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int DW  = SB + 17;
  localparam int PW  = SB + 1;

  localparam logic [PW-1:0] ONE      = PW'(1) << (SB - 1);
  localparam logic [DW-1:0] DIV_BASE = DW'(1) << (SB - 1 + GAIN_FRAC);

  eol_state_t state, state_next;

  // Configuration registers.
  logic                 enable;
  logic [GAIN_BITS-1:0] gain;
  logic [WLEN_BITS-1:0] wlen;

  // Positions and window peak.
  logic [WLEN_BITS-1:0] write_pos, read_pos, scan_cnt;
  logic [PW-1:0]        window_peak, peak_new;
  logic                 scan_vld;
  logic [AW-1:0]        clr_addr;

  // Divider setup and result staging.
  logic [DW-1:0]        prod;
  logic signed [SB-1:0] res_i, res_q;

  logic signed [SB-1:0] in_i, in_q;
  logic                 in_acc, out_free, cfg_we, win_we, scan_go;
  logic [WLEN_BITS-1:0] wlen_new;

  // Memory and unit controls.
  logic                 smp_we, smp_re, env_we, env_re;
  logic [AW-1:0]        smp_waddr, env_waddr, env_raddr;
  logic signed [SB-1:0] smp_wdata_i, smp_wdata_q, smp_rdata_i, smp_rdata_q;
  logic [PW-1:0]        env_wdata, env_rdata, root;
  logic                 isq_start, isq_done, div_start, div_done;
  logic signed [SB-1:0] q_i, q_q;

  assign in_i     = $signed(s_tdata[SB-1:0]);
  assign in_q     = $signed(s_tdata[2*SB-1:SB]);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign win_we   = cfg_we && (paddr[3:2] == REG_WINDOW);
  assign wlen_new = clamp_window(pwdata[WLEN_BITS-1:0], MAX_WINDOW);

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE: prdata = CFG_DATA_BITS'(enable);
      REG_GAIN:   prdata = CFG_DATA_BITS'(gain);
      REG_WINDOW: prdata = CFG_DATA_BITS'(wlen);
      default:    prdata = '0;
    endcase
  end

  // The new envelope may raise the peak; if the envelope it replaced was the peak, the
  // whole window has to be searched again.
  assign peak_new = (root > window_peak) ? root : window_peak;
  assign scan_go  = (env_rdata >= peak_new) && (env_rdata != '0);

  // Next state.
  always_comb begin
    state_next = state;
    if (win_we) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR:     if (clr_addr == AW'(MAX_WINDOW - 1)) state_next = ST_IDLE;
        ST_IDLE:      if (in_acc && enable) state_next = ST_SQRT;
        ST_SQRT:      if (isq_done) state_next = scan_go ? ST_SCAN : ST_MUL;
        ST_SCAN:      if (scan_cnt == wlen - WLEN_BITS'(1)) state_next = ST_SCAN_LAST;
        ST_SCAN_LAST: state_next = ST_MUL;
        ST_MUL:       state_next = (window_peak > ONE) ? ST_DIV_START : ST_OUT;
        ST_DIV_START: state_next = ST_DIV;
        ST_DIV:       if (div_done) state_next = ST_OUT;
        ST_OUT:       if (out_free) state_next = ST_IDLE;
        default:      state_next = ST_CLEAR;
      endcase
    end
  end

  // Memory and unit controls.
  always_comb begin
    smp_we      = 1'b0;
    smp_waddr   = AW'(write_pos);
    smp_wdata_i = in_i;
    smp_wdata_q = in_q;
    smp_re      = 1'b0;
    env_we      = 1'b0;
    env_waddr   = AW'(write_pos);
    env_wdata   = root;
    env_re      = 1'b0;
    env_raddr   = AW'(write_pos);
    isq_start   = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        smp_we      = 1'b1;
        smp_waddr   = clr_addr;
        smp_wdata_i = '0;
        smp_wdata_q = '0;
        env_we      = 1'b1;
        env_waddr   = clr_addr;
        env_wdata   = '0;
      end
      ST_IDLE: begin
        if (in_acc && enable) begin
          smp_we    = 1'b1;
          smp_re    = 1'b1;
          env_re    = 1'b1;
          isq_start = 1'b1;
        end
      end
      ST_SQRT: begin
        env_we = isq_done;
      end
      ST_SCAN: begin
        env_re    = 1'b1;
        env_raddr = AW'(scan_cnt);
      end
      ST_DIV_START: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      enable      <= ENABLE_RST;
      gain        <= GAIN_RST;
      wlen        <= WINDOW_RST;
      write_pos   <= '0;
      read_pos    <= WINDOW_RST >> 1;
      window_peak <= '0;
      clr_addr    <= '0;
      scan_cnt    <= '0;
      scan_vld    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && paddr[3:2] == REG_ENABLE) enable <= pwdata[0];
      if (cfg_we && paddr[3:2] == REG_GAIN) gain <= pwdata[GAIN_BITS-1:0];

      clr_addr <= (state == ST_CLEAR) ? clr_addr + AW'(1) : '0;

      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + WLEN_BITS'(1);
        scan_vld <= 1'b1;
      end else begin
        scan_cnt <= '0;
        scan_vld <= 1'b0;
      end

      if (state == ST_SQRT && isq_done) begin
        window_peak <= scan_go ? '0 : peak_new;
      end else if (scan_vld && env_rdata > window_peak) begin
        window_peak <= env_rdata;
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (in_acc && !enable) begin
        m_tvalid <= 1'b1;
      end else if (state == ST_OUT && out_free) begin
        m_tvalid  <= 1'b1;
        write_pos <= (write_pos == '0) ? wlen - WLEN_BITS'(1) : write_pos - WLEN_BITS'(1);
        read_pos  <= (read_pos == '0) ? wlen - WLEN_BITS'(1) : read_pos - WLEN_BITS'(1);
      end

      if (win_we) begin
        wlen        <= wlen_new;
        write_pos   <= '0;
        read_pos    <= wlen_new >> 1;
        window_peak <= '0;
        clr_addr    <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod  <= DW'(gain) * DW'(window_peak - ONE);
      res_i <= smp_rdata_i;
      res_q <= smp_rdata_q;
    end else if (state == ST_DIV && div_done) begin
      res_i <= q_i;
      res_q <= q_q;
    end
    if (in_acc && !enable) begin
      m_tdata <= TDW'({in_q, in_i});
    end else if (state == ST_OUT && out_free) begin
      m_tdata <= TDW'({res_q, res_i});
    end
  end

  eol_line_mem #(
    .SB    (SB),
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_mem (
    .clk         (clk),
    .smp_we      (smp_we),
    .smp_waddr   (smp_waddr),
    .smp_wdata_i (smp_wdata_i),
    .smp_wdata_q (smp_wdata_q),
    .smp_re      (smp_re),
    .smp_raddr   (AW'(read_pos)),
    .smp_rdata_i (smp_rdata_i),
    .smp_rdata_q (smp_rdata_q),
    .env_we      (env_we),
    .env_waddr   (env_waddr),
    .env_wdata   (env_wdata),
    .env_re      (env_re),
    .env_raddr   (env_raddr),
    .env_rdata   (env_rdata)
  );

  eol_isqrt #(
    .SB (SB)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (isq_start),
    .x_i   (in_i),
    .x_q   (in_q),
    .done  (isq_done),
    .root  (root)
  );

  eol_divider #(
    .SB (SB),
    .DW (DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .x_i     (res_i),
    .x_q     (res_q),
    .divisor (DIV_BASE + prod),
    .done    (div_done),
    .q_i     (q_i),
    .q_q     (q_q)
  );

endmodule

// ----- design/eol_line_mem.sv -----
// Sample delay lines and envelope line, each a synchronous memory with registered read.
module eol_line_mem import eol_pkg::*; #(
  parameter int SB    = SAMPLE_BITS_DEF,
  parameter int DEPTH = MAX_WINDOW_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 smp_we,
  input  logic [AW-1:0]        smp_waddr,
  input  logic signed [SB-1:0] smp_wdata_i,
  input  logic signed [SB-1:0] smp_wdata_q,
  input  logic                 smp_re,
  input  logic [AW-1:0]        smp_raddr,
  output logic signed [SB-1:0] smp_rdata_i,
  output logic signed [SB-1:0] smp_rdata_q,
  input  logic                 env_we,
  input  logic [AW-1:0]        env_waddr,
  input  logic [SB:0]          env_wdata,
  input  logic                 env_re,
  input  logic [AW-1:0]        env_raddr,
  output logic [SB:0]          env_rdata
);

  logic signed [SB-1:0] line_i [DEPTH];
  logic signed [SB-1:0] line_q [DEPTH];
  logic [SB:0]          line_env [DEPTH];

  always_ff @(posedge clk) begin
    if (smp_we) begin
      line_i[smp_waddr] <= smp_wdata_i;
      line_q[smp_waddr] <= smp_wdata_q;
    end
    if (smp_re) begin
      smp_rdata_i <= line_i[smp_raddr];
      smp_rdata_q <= line_q[smp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (env_we) begin
      line_env[env_waddr] <= env_wdata;
    end
    if (env_re) begin
      env_rdata <= line_env[env_raddr];
    end
  end

endmodule

// ----- design/eol_isqrt.sv -----
// Iterative magnitude unit: squares I and Q, then takes the integer square root bit by bit.
module eol_isqrt import eol_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SB-1:0] x_i,
  input  logic signed [SB-1:0] x_q,
  output logic                 done,
  output logic [SB:0]          root
);

  localparam int VW = 2 * SB;
  localparam int CW = $clog2(SB + 1);

  logic signed [VW-1:0] sq_i, sq_q;
  logic [VW-1:0]        v, res, bitv;
  logic [CW-1:0]        cnt;
  logic                 load, busy;
  logic [VW-1:0]        trial;

  assign trial = res + bitv;
  assign root  = {1'b0, res[SB-1:0]};

  always_ff @(posedge clk) begin
    if (start) begin
      sq_i <= x_i * x_i;
      sq_q <= x_q * x_q;
    end
    if (load) begin
      v    <= VW'(sq_i) + VW'(sq_q);
      res  <= '0;
      bitv <= VW'(1) << (VW - 2);
      cnt  <= '0;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= 1'b0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      load <= start;
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(SB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- design/eol_divider.sv -----
// Two-lane serial restoring divider that scales the delayed I and Q by the same divisor.
module eol_divider import eol_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF,
  parameter int DW = SB + 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SB-1:0] x_i,
  input  logic signed [SB-1:0] x_q,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic signed [SB-1:0] q_i,
  output logic signed [SB-1:0] q_q
);

  // The dividend is the magnitude followed by SB-1+GAIN_FRAC zero bits.
  localparam int NSTEP = 2 * SB - 1 + GAIN_FRAC;
  localparam int CW    = $clog2(NSTEP + 1);

  logic [SB-1:0] num_i, num_q, quo_i, quo_q;
  logic [DW-1:0] rem_i, rem_q, dv;
  logic          neg_i, neg_q, busy;
  logic [CW-1:0] cnt;
  logic          bit_i, bit_q, take_i, take_q;
  logic [DW:0]   sh_i, sh_q;

  always_comb begin
    bit_i  = (cnt < CW'(SB)) ? num_i[SB-1] : 1'b0;
    bit_q  = (cnt < CW'(SB)) ? num_q[SB-1] : 1'b0;
    sh_i   = {rem_i, bit_i};
    sh_q   = {rem_q, bit_q};
    take_i = sh_i >= {1'b0, dv};
    take_q = sh_q >= {1'b0, dv};
  end

  assign q_i = neg_i ? -$signed(quo_i) : $signed(quo_i);
  assign q_q = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk) begin
    if (start) begin
      neg_i <= x_i[SB-1];
      neg_q <= x_q[SB-1];
      num_i <= x_i[SB-1] ? SB'(-x_i) : SB'(x_i);
      num_q <= x_q[SB-1] ? SB'(-x_q) : SB'(x_q);
      rem_i <= '0;
      rem_q <= '0;
      quo_i <= '0;
      quo_q <= '0;
      dv    <= divisor;
      cnt   <= '0;
    end else if (busy) begin
      num_i <= num_i << 1;
      num_q <= num_q << 1;
      rem_i <= take_i ? DW'(sh_i - {1'b0, dv}) : DW'(sh_i);
      rem_q <= take_q ? DW'(sh_q - {1'b0, dv}) : DW'(sh_q);
      quo_i <= {quo_i[SB-2:0], take_i};
      quo_q <= {quo_q[SB-2:0], take_q};
      cnt   <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(NSTEP - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
